// ===== design/umq_pkg.sv =====
// Shared types and codes for the unsorted min/max priority queue.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package umq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef logic [DATA_W-1:0] data_t;

    // Request codes on req_type
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_MAX    = 2'd1,
        REQ_MIN    = 2'd2,
        REQ_SEARCH = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_REFUSED   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

// ===== design/umq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module umq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/unsorted_min_max_priority_queue.sv =====
// Top level of the double-ended priority queue over an unsorted value store.
// Depends on umq_pkg (types, codes) and umq_ram (entry store).
`timescale 1ns / 1ps

// Usage:
//   A transaction is accepted at a rising edge with start high and busy low;
//   req_type and value are sampled there. Exactly one result follows, shown
//   for a single cycle on result_value, status and entry_count with done high.
//   The receiver cannot stall: done is a one-cycle strobe.
// Sequence:
//   Insert, refused extract, insert into a full store and search of an empty
//   store finish at once (done in the cycle after acceptance).
//   Extract-max, extract-min and search scan every stored entry: the store
//   RAM has one read port, so the scan reads one entry per cycle through the
//   shared comparators, then a final step (S_LAST) folds in the last entry and,
//   for an extract, writes the last entry into the freed slot.
// Throughput:
//   busy stays low for results given at once; for a scan it is high from
//   acceptance until the cycle done rises, and a new transaction may be accepted in the done cycle.
// Reset:
//   rst_n (async, active low) empties the store; no clearing pass is needed,
//   since only entries below the occupancy are ever used.
module unsorted_min_max_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] value,
    output logic        done,
    output logic [31:0] result_value,
    output logic [1:0]  status,
    output logic [4:0]  entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST
    } state_t;

    state_t                   state_reg,    state_next;
    logic [CW-1:0]            occ_reg,      occ_next;
    umq_pkg::req_t            req_reg,      req_next;
    umq_pkg::data_t           val_reg,      val_next;
    logic [AW-1:0]            scan_idx_reg, scan_idx_next;
    logic                     rvalid_reg,   rvalid_next;
    logic [AW-1:0]            ridx_reg,     ridx_next;
    umq_pkg::data_t           best_val_reg, best_val_next;
    logic [AW-1:0]            best_idx_reg, best_idx_next;
    logic                     found_reg,    found_next;
    umq_pkg::data_t           res_val_reg,  res_val_next;
    umq_pkg::status_t         status_reg,   status_next;
    logic                     done_reg,     done_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    umq_pkg::data_t           ram_wdata;
    logic [AW-1:0]            ram_raddr;
    umq_pkg::data_t           ram_rdata;

    logic                     accept;
    umq_pkg::req_t            req_in;
    logic                     cmp_gt;
    logic                     cmp_lt;
    logic                     cmp_eq;
    logic                     better;
    logic [AW-1:0]            last_idx;

    assign accept   = start && !busy;
    assign req_in   = umq_pkg::req_t'(req_type);
    assign last_idx = AW'(occ_reg - CW'(1));

    // Shared comparator: RAM read data against running best / search key
    assign cmp_gt = $signed(ram_rdata) > $signed(best_val_reg);
    assign cmp_lt = $signed(ram_rdata) < $signed(best_val_reg);
    assign cmp_eq = ram_rdata == val_reg;
    assign better = (req_reg == umq_pkg::REQ_MAX) ? cmp_gt : cmp_lt;

    umq_ram #(
        .WIDTH (umq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer next-state logic
    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        req_next      = req_reg;
        val_next      = val_reg;
        scan_idx_next = scan_idx_reg;
        rvalid_next   = 1'b0;
        ridx_next     = ridx_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        res_val_next  = res_val_reg;
        status_next   = status_reg;
        done_next     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = AW'(occ_reg);
        ram_wdata     = value;
        ram_raddr     = scan_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next      = req_in;
                    val_next      = value;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    res_val_next  = '0;
                    status_next   = umq_pkg::ST_OK;
                    unique case (req_in)
                        umq_pkg::REQ_INSERT:
                        begin
                            done_next = 1'b1;
                            if (occ_reg >= CW'(DEPTH))
                            begin
                                status_next = umq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                occ_next = occ_reg + CW'(1);
                            end
                        end
                        umq_pkg::REQ_MAX, umq_pkg::REQ_MIN:
                        begin
                            if (occ_reg <= CW'(1))
                            begin
                                status_next = umq_pkg::ST_REFUSED;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        umq_pkg::REQ_SEARCH:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = umq_pkg::ST_NOT_FOUND;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle
                rvalid_next   = 1'b1;
                ridx_next     = scan_idx_reg;
                scan_idx_next = scan_idx_reg + AW'(1);
                if (scan_idx_reg == last_idx)
                begin
                    state_next = S_LAST;
                end
                // Fold in the entry read last cycle
                if (rvalid_reg)
                begin
                    if (ridx_reg == '0 || better)
                    begin
                        best_val_next = ram_rdata;
                        best_idx_next = ridx_reg;
                    end
                    if (cmp_eq)
                    begin
                        found_next = 1'b1;
                    end
                end
            end

            S_LAST:
            begin
                // ram_rdata holds the last occupied entry
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (req_reg == umq_pkg::REQ_SEARCH)
                begin
                    if (found_reg || cmp_eq)
                    begin
                        res_val_next = val_reg;
                        status_next  = umq_pkg::ST_OK;
                    end
                    else
                    begin
                        res_val_next = '0;
                        status_next  = umq_pkg::ST_NOT_FOUND;
                    end
                end
                else
                begin
                    // Move the last entry into the extracted slot
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    ram_waddr = better ? ridx_reg : best_idx_reg;
                    res_val_next = better ? ram_rdata : best_val_reg;
                    status_next  = umq_pkg::ST_OK;
                    occ_next     = occ_reg - CW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        val_reg      <= val_next;
        scan_idx_reg <= scan_idx_next;
        ridx_reg     <= ridx_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        res_val_reg  <= res_val_next;
        status_reg   <= status_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign result_value = res_val_reg;
    assign status       = status_reg;
    assign entry_count  = umq_pkg::COUNT_W'(occ_reg);

    // Checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_last_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LAST |-> rvalid_reg)
        else $error("final scan step without read data");

    a_occ_moves_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != $past(occ_reg) |-> done)
        else $error("occupancy changed without a result");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == umq_pkg::ST_REFUSED || status == umq_pkg::ST_FULL)
            |-> result_value == '0)
        else $error("refused transaction returned a value");

endmodule

// ===== sim/tb_unsorted_min_max_priority_queue.sv =====
// Self-checking testbench for unsorted_min_max_priority_queue (DEPTH = 16).
// Needs umq_pkg and the block's RTL; a directed table, then random traffic,
// checked against the table's own expected outcomes or an in-bench queue predictor.
`timescale 1ns / 1ps

module tb_unsorted_min_max_priority_queue;

    localparam int          DEPTH       = 16;
    localparam int          RAND_ITEMS  = 1020;
    localparam int          CALM_ITEMS  = 100;
    localparam int          DRAIN_WAIT  = 25;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Expected outcome of one request
    typedef struct packed {
        umq_pkg::data_t   res_value;
        umq_pkg::status_t res_status;
        logic [4:0]       res_count;
    } pq_outcome_t;

    // One directed stimulus row; typed rows carry their own expected outcome
    typedef struct packed {
        umq_pkg::req_t  req;
        umq_pkg::data_t val;
        logic           typed;
        pq_outcome_t    want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [31:0] value;
    logic        done;
    logic [31:0] result_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;

    // Predictor state and the results still owed by the block
    umq_pkg::data_t pq_store [DEPTH];
    int unsigned    pq_count;
    pq_outcome_t    pq_results_due [$];
    dir_row_t       dir_rows [$];
    pq_outcome_t    due;
    int unsigned    err_count;
    int unsigned    cycle_count;

    unsorted_min_max_priority_queue #(
        .DEPTH(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .status       (status),
        .entry_count  (entry_count)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor: applies one request to the model store and returns its outcome
    function automatic pq_outcome_t pq_apply_request(umq_pkg::req_t req, umq_pkg::data_t val);
        pq_outcome_t o;
        int unsigned best;
        int unsigned i;
        o.res_value  = '0;
        o.res_status = umq_pkg::ST_OK;
        case (req)
            umq_pkg::REQ_INSERT:
            begin
                if (pq_count >= DEPTH)
                    o.res_status = umq_pkg::ST_FULL;
                else
                begin
                    pq_store[pq_count] = val;
                    pq_count++;
                end
            end
            umq_pkg::REQ_MAX, umq_pkg::REQ_MIN:
            begin
                if (pq_count <= 1)
                    o.res_status = umq_pkg::ST_REFUSED;
                else
                begin
                    // first index holding the extreme wins
                    best = 0;
                    for (i = 1; i < pq_count; i++)
                    begin
                        if (req == umq_pkg::REQ_MAX
                                ? ($signed(pq_store[i]) > $signed(pq_store[best]))
                                : ($signed(pq_store[i]) < $signed(pq_store[best])))
                            best = i;
                    end
                    o.res_value    = pq_store[best];
                    pq_store[best] = pq_store[pq_count-1];
                    pq_count--;
                end
            end
            default:
            begin
                o.res_status = umq_pkg::ST_NOT_FOUND;
                for (i = 0; i < pq_count; i++)
                begin
                    if (pq_store[i] == val && o.res_status == umq_pkg::ST_NOT_FOUND)
                    begin
                        o.res_status = umq_pkg::ST_OK;
                        o.res_value  = val;
                    end
                end
            end
        endcase
        o.res_count = pq_count[4:0];
        return o;
    endfunction

    function automatic dir_row_t mk_row(umq_pkg::req_t req, umq_pkg::data_t val, int typed,
                                        umq_pkg::data_t w_val, umq_pkg::status_t w_st,
                                        int w_cnt);
        dir_row_t r;
        r.req  = req;
        r.val  = val;
        r.typed = (typed != 0);
        r.want.res_value  = w_val;
        r.want.res_status = w_st;
        r.want.res_count  = 5'(w_cnt);
        return r;
    endfunction

    // Random value biased toward extremes and a small pool, so duplicates occur
    function automatic umq_pkg::data_t pick_value();
        umq_pkg::data_t v;
        case ($urandom_range(0, 9))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = '0;
            3, 4, 5: v = umq_pkg::data_t'($urandom_range(0, 7)) - 32'd4;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Present one transaction and hold it until accepted
    task automatic send_item(umq_pkg::req_t req, umq_pkg::data_t val, logic typed,
                             pq_outcome_t want);
        pq_outcome_t got;
        @(negedge clk);
        start    = 1'b1;
        req_type = req;
        value    = val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        got = pq_apply_request(req, val);
        pq_results_due.push_back(typed ? want : got);
    endtask

    // Drop start for an idle gap set by n; the other inputs carry noise meanwhile
    task automatic idle_for(int unsigned n);
        @(negedge clk);
        start    = 1'b0;
        req_type = 2'($urandom);
        value    = $urandom;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // Result checker: every done is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pq_results_due.size() == 0)
            begin
                $display("%0t: unexpected result: value %h status %0d count %0d",
                         $time, result_value, status, entry_count);
                err_count++;
            end
            else
            begin
                due = pq_results_due.pop_front();
                if (result_value !== due.res_value)
                begin
                    $display("%0t: result_value mismatch: expected %h, actual %h",
                             $time, due.res_value, result_value);
                    err_count++;
                end
                if (status !== due.res_status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, due.res_status, status);
                    err_count++;
                end
                if (entry_count !== due.res_count)
                begin
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $time, due.res_count, entry_count);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_unsorted_min_max_priority_queue: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        umq_pkg::req_t  r;
        umq_pkg::data_t v;
        int unsigned    mode;
        logic           gaps_on;
        int             n;

        err_count   = 0;
        cycle_count = 0;
        pq_count    = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = umq_pkg::REQ_INSERT;
        value       = '0;

        // Directed table: empty store, single entry, duplicates, extremes, full
        dir_rows.push_back(mk_row(umq_pkg::REQ_MAX,    32'h0,         1,
                                  32'h0,         umq_pkg::ST_REFUSED,   0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_SEARCH, 32'h0,         1,
                                  32'h0,         umq_pkg::ST_NOT_FOUND, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h0,         1,
                                  32'h0,         umq_pkg::ST_OK,        1));
        dir_rows.push_back(mk_row(umq_pkg::REQ_SEARCH, 32'h0,         1,
                                  32'h0,         umq_pkg::ST_OK,        1));
        dir_rows.push_back(mk_row(umq_pkg::REQ_MIN,    32'hFFFF_FFFF, 1,
                                  32'h0,         umq_pkg::ST_REFUSED,   1));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 1,
                                  32'h0,         umq_pkg::ST_OK,        2));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 1,
                                  32'h0,         umq_pkg::ST_OK,        3));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h8000_0000, 1,
                                  32'h0,         umq_pkg::ST_OK,        4));
        dir_rows.push_back(mk_row(umq_pkg::REQ_MAX,    32'h0,         1,
                                  32'h7FFF_FFFF, umq_pkg::ST_OK,        3));
        dir_rows.push_back(mk_row(umq_pkg::REQ_SEARCH, 32'h7FFF_FFFF, 1,
                                  32'h7FFF_FFFF, umq_pkg::ST_OK,        3));
        dir_rows.push_back(mk_row(umq_pkg::REQ_SEARCH, 32'h1,         1,
                                  32'h0,         umq_pkg::ST_NOT_FOUND, 3));
        // fill up to capacity; checked by the predictor
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h0000_0001, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h5555_5555, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'hAAAA_AAAA, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h7FFF_FFFE, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h8000_0001, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h0001_0000, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'hFFFF_0000, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h0F0F_0F0F, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'hF0F0_F0F0, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h0000_0002, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'hFFFF_FFFE, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h0000_0000, 0, '0, umq_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(umq_pkg::REQ_INSERT, 32'h1234_5678, 1,
                                  32'h0,         umq_pkg::ST_FULL,      16));
        dir_rows.push_back(mk_row(umq_pkg::REQ_MIN,    32'h0,         1,
                                  32'h8000_0000, umq_pkg::ST_OK,        15));
        dir_rows.push_back(mk_row(umq_pkg::REQ_MAX,    32'h0,         0, '0, umq_pkg::ST_OK, 0));

        // Hold reset low, then release it
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with occasional gaps
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].req, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
            if ($urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 9));
        end

        // Random part: fill, drain and mixed phases of 40 transactions each
        mode    = 2;
        gaps_on = 1'b1;
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                mode    = $urandom_range(0, 2);
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            case (mode)
                0:       r = ($urandom_range(0, 99) < 70)
                             ? umq_pkg::REQ_INSERT
                             : umq_pkg::req_t'($urandom_range(1, 3));
                1:       r = ($urandom_range(0, 99) < 70)
                             ? umq_pkg::req_t'($urandom_range(1, 2))
                             : umq_pkg::req_t'($urandom_range(0, 3));
                default: r = umq_pkg::req_t'($urandom_range(0, 3));
            endcase
            // searches hit a stored entry about half the time
            if (r == umq_pkg::REQ_SEARCH && pq_count > 0 && $urandom_range(0, 1) == 1)
                v = pq_store[$urandom_range(0, pq_count - 1)];
            else if (r == umq_pkg::REQ_MAX || r == umq_pkg::REQ_MIN)
                v = $urandom;
            else
                v = pick_value();
            send_item(r, v, 1'b0, '0);
            if (gaps_on && n < RAND_ITEMS - CALM_ITEMS && $urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 9));
        end

        @(negedge clk);
        start = 1'b0;

        // Wait for the last results, then a little longer for stray strobes
        while (pq_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        if (err_count == 0)
            $display("tb_unsorted_min_max_priority_queue: clean");
        else
            $display("tb_unsorted_min_max_priority_queue: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/umq_pkg.sv
design/umq_ram.sv
design/unsorted_min_max_priority_queue.sv
sim/tb_unsorted_min_max_priority_queue.sv
